// File: hdl/vtrof_pkg.sv
// ----------------------------------------------------------------------------
// vtrof_pkg
// Shared constants and types of the vertical three-row OR filter.
// ----------------------------------------------------------------------------
package vtrof_pkg;

	localparam int MAX_ROW_LENGTH = 1024;
	localparam int ADDR_W         = $clog2(MAX_ROW_LENGTH);
	localparam int LEN_W          = 11;
	localparam int ROWS_W         = 12;
	localparam int PIX_W          = 24;
	localparam int APB_AW         = 3;
	localparam int APB_DW         = 32;

	localparam logic [LEN_W-1:0]  ROW_LENGTH_RESET = LEN_W'(640);
	localparam logic [ROWS_W-1:0] ROW_COUNT_RESET  = ROWS_W'(480);
	localparam logic [LEN_W-1:0]  MAX_LEN          = LEN_W'(MAX_ROW_LENGTH);

	// Register index as decoded from the word address.
	typedef enum logic {
		REG_ROW_LENGTH = 1'b0,
		REG_ROW_COUNT  = 1'b1
	} reg_idx_t;

	// Request kinds on the input stream.
	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	// Control of the request held between the memory read and the write-back.
	typedef struct packed {
		logic              valid;
		logic              drain;
		logic              produce;
		logic              use_older;
		logic              last;
		logic              write;
		logic [ADDR_W-1:0] addr;
	} item_t;

endpackage

// File: hdl/vertical_three_row_or_filter.sv
// ----------------------------------------------------------------------------
// vertical_three_row_or_filter
// Per-channel OR of three vertically adjacent pixels, with two line buffers.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// s_*       in         pixel request or drain tick (tuser), pixel in tdata
// m_*       out        filtered pixel in tdata, end of frame in tlast
// APB       in/out     row_length at 0x0, row_count at 0x4
//
// One request is taken per cycle while s_tready is high; each result is
// registered by the read of the line-buffer memories, with the write-back
// stage behind it, and then by a three-entry output queue that takes the
// results, so s_tready depends on registered state only and falls only while
// that queue is nearly full. Reset clears positions, the drain flag and the
// queue; the line buffers are not cleared.
// ----------------------------------------------------------------------------
module vertical_three_row_or_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,  // in_blue, in_green, in_red
	input  logic                          s_tuser,  // operation
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,  // out_blue, out_green, out_red
	output logic                          m_tlast,  // frame_end
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vtrof_pkg::APB_AW-1:0]  paddr,
	input  logic [vtrof_pkg::APB_DW-1:0]  pwdata,
	output logic [vtrof_pkg::APB_DW-1:0]  prdata,
	output logic                          pready
);

	localparam int AW   = vtrof_pkg::ADDR_W;
	localparam int LW   = vtrof_pkg::LEN_W;
	localparam int RW   = vtrof_pkg::ROWS_W;
	localparam int PW   = vtrof_pkg::PIX_W;
	localparam int QD   = 3;
	localparam int QW   = $clog2(QD);
	localparam int CW   = $clog2(QD + 1);

	// Configuration.
	logic [LW-1:0] row_length_q;
	logic [RW-1:0] row_count_q;
	logic          cfg_wr;

	// Positions.
	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] dpos_q;
	logic          pending_q;

	// Stage 0 decode.
	logic [LW-1:0] len_eff;
	logic [AW-1:0] len_m1;
	logic [RW-1:0] rows_eff;
	logic [RW-1:0] rows_m1;
	logic [AW-1:0] x_s0;
	logic [RW-1:0] r_s0;
	logic [AW-1:0] d_s0;
	logic          is_drain;
	logic          accept;
	vtrof_pkg::item_t item_s0;

	// Stage 1.
	vtrof_pkg::item_t item_s1;
	logic [PW-1:0] px_s1;
	logic          fwd_s1;
	logic [PW-1:0] fwd_newer_s1;
	logic [PW-1:0] fwd_older_s1;
	logic [PW-1:0] newer_rd;
	logic [PW-1:0] older_rd;
	logic [PW-1:0] newer_v;
	logic [PW-1:0] older_v;
	logic [PW-1:0] result;
	logic          fwd_hit;
	logic          push;
	logic          pop;

	// Output queue.
	logic [PW:0]   queue_q [QD];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [CW-1:0] occ_q;
	logic [CW:0]   occ_need;

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= vtrof_pkg::ROW_LENGTH_RESET;
			row_count_q  <= vtrof_pkg::ROW_COUNT_RESET;
		end else if (cfg_wr) begin
			unique case (vtrof_pkg::reg_idx_t'(paddr[2]))
				vtrof_pkg::REG_ROW_LENGTH: row_length_q <= pwdata[LW-1:0];
				vtrof_pkg::REG_ROW_COUNT:  row_count_q  <= pwdata[RW-1:0];
				default:                   row_length_q <= row_length_q;
			endcase
		end
	end

	always_comb begin
		unique case (vtrof_pkg::reg_idx_t'(paddr[2]))
			vtrof_pkg::REG_ROW_LENGTH: prdata = {{(vtrof_pkg::APB_DW-LW){1'b0}}, row_length_q};
			vtrof_pkg::REG_ROW_COUNT:  prdata = {{(vtrof_pkg::APB_DW-RW){1'b0}}, row_count_q};
			default:                   prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- stage 0
	always_comb begin
		if (row_length_q == '0) begin
			len_eff = LW'(1);
		end else if (row_length_q > vtrof_pkg::MAX_LEN) begin
			len_eff = vtrof_pkg::MAX_LEN;
		end else begin
			len_eff = row_length_q;
		end
		len_m1   = AW'(len_eff - LW'(1));
		rows_eff = (row_count_q == '0) ? RW'(1) : row_count_q;
		rows_m1  = rows_eff - RW'(1);

		// Positions beyond a newly narrowed frame saturate to the last place.
		x_s0 = ({1'b0, col_q} >= len_eff) ? len_m1 : col_q;
		d_s0 = ({1'b0, dpos_q} >= len_eff) ? len_m1 : dpos_q;
		r_s0 = (row_q >= rows_eff) ? rows_m1 : row_q;
	end

	assign is_drain = (vtrof_pkg::op_t'(s_tuser) == vtrof_pkg::OP_DRAIN);

	always_comb begin
		item_s0 = '0;
		if (is_drain) begin
			item_s0.valid     = accept && pending_q;
			item_s0.drain     = 1'b1;
			item_s0.produce   = 1'b1;
			item_s0.use_older = (rows_eff != RW'(1));
			item_s0.last      = (d_s0 == len_m1);
			item_s0.addr      = d_s0;
		end else begin
			item_s0.valid     = accept && !pending_q;
			item_s0.produce   = (r_s0 != '0);
			item_s0.use_older = (r_s0 > RW'(1));
			item_s0.write     = 1'b1;
			item_s0.addr      = x_s0;
		end
	end

	// Accept while the queue can still take everything already in flight.
	assign occ_need = {1'b0, occ_q} + (CW+1)'(item_s1.valid && item_s1.produce);
	assign s_tready = (occ_need <= (CW+1)'(QD - 1));
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			dpos_q    <= '0;
			pending_q <= 1'b0;
		end else if (accept) begin
			if (is_drain) begin
				if (pending_q) begin
					if (d_s0 == len_m1) begin
						pending_q <= 1'b0;
						dpos_q    <= '0;
					end else begin
						dpos_q <= d_s0 + AW'(1);
					end
				end
			end else if (!pending_q) begin
				if (x_s0 == len_m1) begin
					col_q <= '0;
					if (r_s0 == rows_m1) begin
						row_q     <= '0;
						pending_q <= 1'b1;
						dpos_q    <= '0;
					end else begin
						row_q <= r_s0 + RW'(1);
					end
				end else begin
					col_q <= x_s0 + AW'(1);
					row_q <= r_s0;
				end
			end
		end
	end

	// The write-back of stage 1 lands on the same edge as the next read, so a
	// read of the entry being written takes the new contents instead.
	assign fwd_hit = item_s1.valid && item_s1.write && (item_s1.addr == item_s0.addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1 <= item_s0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1        <= s_tdata;
			fwd_s1       <= fwd_hit;
			fwd_newer_s1 <= px_s1;
			fwd_older_s1 <= newer_v;
		end
	end

	// ---------------------------------------------------------------- memories
	vtrof_ram #(
		.WIDTH (PW),
		.DEPTH (vtrof_pkg::MAX_ROW_LENGTH)
	) u_newer_ram (
		.clk   (clk),
		.we    (item_s1.valid && item_s1.write),
		.waddr (item_s1.addr),
		.wdata (px_s1),
		.re    (accept),
		.raddr (item_s0.addr),
		.rdata (newer_rd)
	);

	vtrof_ram #(
		.WIDTH (PW),
		.DEPTH (vtrof_pkg::MAX_ROW_LENGTH)
	) u_older_ram (
		.clk   (clk),
		.we    (item_s1.valid && item_s1.write),
		.waddr (item_s1.addr),
		.wdata (newer_v),
		.re    (accept),
		.raddr (item_s0.addr),
		.rdata (older_rd)
	);

	// ---------------------------------------------------------------- stage 1
	always_comb begin
		newer_v = fwd_s1 ? fwd_newer_s1 : newer_rd;
		older_v = fwd_s1 ? fwd_older_s1 : older_rd;
		result  = newer_v | (item_s1.use_older ? older_v : '0);
		if (!item_s1.drain) begin
			result = result | px_s1;
		end
	end

	// ---------------------------------------------------------------- output
	assign push = item_s1.valid && item_s1.produce;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QW'(QD - 1)) ? '0 : wr_ptr_q + QW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QW'(QD - 1)) ? '0 : rd_ptr_q + QW'(1);
			end
			occ_q <= occ_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= {item_s1.drain && item_s1.last, result};
		end
	end

	assign m_tvalid = (occ_q != '0);
	assign m_tdata  = queue_q[rd_ptr_q][PW-1:0];
	assign m_tlast  = queue_q[rd_ptr_q][PW];

endmodule

// File: hdl/vtrof_ram.sv
// ----------------------------------------------------------------------------
// vtrof_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module vtrof_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/vtrof_checker.sv
// ----------------------------------------------------------------------------
// vtrof_checker
// Port-level checks of the vertical three-row OR filter, bound to the top.
// ----------------------------------------------------------------------------
module vtrof_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [23:0]                   s_tdata,
	input logic                          s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [23:0]                   m_tdata,
	input logic                          m_tlast,
	input logic                          pready
);

	// A held result keeps its contents until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// A waiting request keeps its contents until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("request changed while waiting");

	// The input side only stalls while results are waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	// A newly valid result traces back to a request taken ahead of the stage-1 register and the output queue.
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a request two cycles earlier");

	// The configuration port never waits.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind vertical_three_row_or_filter vtrof_checker u_vtrof_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.pready   (pready)
);

// File: dv/vertical_three_row_or_filter_tb.sv
// ----------------------------------------------------------------------------
// vertical_three_row_or_filter_tb
// Self-checking bench for the vertical three-row OR filter.
// ----------------------------------------------------------------------------
// Frames of pixel requests and drain ticks are queued by the stimulus process
// and driven with random idle bursts, while the output side stalls at random.
// A behavioural copy of the line buffers and frame positions predicts every
// filtered pixel on acceptance of its request, and each result is compared
// per channel and end-of-frame flag against the oldest prediction. Row
// length and row count are changed over APB between frames, including
// extreme, out-of-range and mid-frame settings.
// ----------------------------------------------------------------------------
module vertical_three_row_or_filter_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS   = 1000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		vtrof_pkg::op_t op;
		logic [7:0]     blue;
		logic [7:0]     green;
		logic [7:0]     red;
	} pixel_req_t;

	typedef struct {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       frame_end;
	} filt_pixel_t;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [23:0]                  s_tdata  = '0;  // in_blue, in_green, in_red
	logic                         s_tuser  = vtrof_pkg::OP_PIXEL;  // operation
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [23:0]                  m_tdata;  // out_blue, out_green, out_red
	logic                         m_tlast;  // frame_end
	logic                         psel     = 1'b0;
	logic                         penable  = 1'b0;
	logic                         pwrite   = 1'b0;
	logic [vtrof_pkg::APB_AW-1:0] paddr    = '0;
	logic [vtrof_pkg::APB_DW-1:0] pwdata   = '0;
	logic [vtrof_pkg::APB_DW-1:0] prdata;
	logic                         pready;

	vertical_three_row_or_filter dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	pixel_req_t  request_q[$];
	filt_pixel_t filtered_q[$];

	int send_idle_pct  = 0;
	int stall_pct      = 0;
	int send_gap       = 0;
	int stall_left     = 0;
	int error_count    = 0;
	int requests_taken = 0;
	int results_seen   = 0;
	int frames_seen    = 0;
	int reg_writes     = 0;
	int shaped_count   = 0;
	int quiet_cycles   = 0;

	// Behavioural copy of the filter: configuration, line buffers, positions.
	logic [vtrof_pkg::LEN_W-1:0]  len_reg  = vtrof_pkg::ROW_LENGTH_RESET;
	logic [vtrof_pkg::ROWS_W-1:0] rows_reg = vtrof_pkg::ROW_COUNT_RESET;
	logic [vtrof_pkg::PIX_W-1:0]  row_back1 [vtrof_pkg::MAX_ROW_LENGTH];
	logic [vtrof_pkg::PIX_W-1:0]  row_back2 [vtrof_pkg::MAX_ROW_LENGTH];
	int                           pos_col   = 0;
	int                           pos_row   = 0;
	int                           flush_col = 0;
	bit                           flushing  = 1'b0;

	function automatic int active_len();
		if (len_reg == 0) return 1;
		if (len_reg > vtrof_pkg::MAX_ROW_LENGTH) return vtrof_pkg::MAX_ROW_LENGTH;
		return int'(len_reg);
	endfunction

	function automatic int active_rows();
		return (rows_reg == 0) ? 1 : int'(rows_reg);
	endfunction

	function automatic void flag_error(string what, logic [31:0] want, logic [31:0] got);
		error_count++;
		if (error_count <= 10)
			$display("ERROR at %0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
	endfunction

	function automatic void expect_pixel(logic [vtrof_pkg::PIX_W-1:0] v, logic fin);
		filt_pixel_t e;
		e.blue      = v[7:0];
		e.green     = v[15:8];
		e.red       = v[23:16];
		e.frame_end = fin;
		filtered_q.push_back(e);
	endfunction

	function automatic void predict_request(vtrof_pkg::op_t op,
			logic [vtrof_pkg::PIX_W-1:0] px);
		int len;
		int rows;
		int x;
		int r;
		logic [vtrof_pkg::PIX_W-1:0] acc;
		len  = active_len();
		rows = active_rows();
		if (op == vtrof_pkg::OP_DRAIN) begin
			if (!flushing)
				return;
			x   = (flush_col >= len) ? len - 1 : flush_col;
			acc = row_back1[x];
			if (rows > 1)
				acc |= row_back2[x];
			expect_pixel(acc, x == len - 1);
			if (x == len - 1) begin
				flushing  = 1'b0;
				flush_col = 0;
			end else begin
				flush_col = x + 1;
			end
			return;
		end
		// Pixels that arrive while the last row is still draining are dropped.
		if (flushing)
			return;
		x = (pos_col >= len) ? len - 1 : pos_col;
		r = (pos_row >= rows) ? rows - 1 : pos_row;
		if (r > 0) begin
			acc = row_back1[x] | px;
			if (r > 1)
				acc |= row_back2[x];
			expect_pixel(acc, 1'b0);
		end
		row_back2[x] = row_back1[x];
		row_back1[x] = px;
		if (x == len - 1) begin
			pos_col = 0;
			if (r == rows - 1) begin
				pos_row   = 0;
				flushing  = 1'b1;
				flush_col = 0;
			end else begin
				pos_row = r + 1;
			end
		end else begin
			pos_col = x + 1;
			pos_row = r;
		end
	endfunction

	// Request driver: random idle bursts between requests.
	always @(posedge clk or negedge arst_n) begin : drive
		pixel_req_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
				send_gap <= $urandom_range(8);
				s_tvalid <= 1'b0;
			end else if (request_q.size() != 0) begin
				req = request_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {req.red, req.green, req.blue};
				s_tuser  <= req.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: predicts on each accepted request, then checks each accepted result.
	always @(posedge clk or negedge arst_n) begin : observe
		filt_pixel_t want;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				requests_taken++;
				predict_request(vtrof_pkg::op_t'(s_tuser), s_tdata);
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tlast)
					frames_seen++;
				if (filtered_q.size() == 0) begin
					flag_error("result with nothing expected, tdata", '0, 32'(m_tdata));
				end else begin
					want = filtered_q.pop_front();
					if (m_tdata[7:0] !== want.blue)
						flag_error("blue channel", 32'(want.blue), 32'(m_tdata[7:0]));
					if (m_tdata[15:8] !== want.green)
						flag_error("green channel", 32'(want.green), 32'(m_tdata[15:8]));
					if (m_tdata[23:16] !== want.red)
						flag_error("red channel", 32'(want.red), 32'(m_tdata[23:16]));
					if (m_tlast !== want.frame_end)
						flag_error("frame end (tlast)", 32'(want.frame_end), 32'(m_tlast));
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				stall_left <= $urandom_range(8);
				m_tready   <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, filtered_q.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic apb_access(input logic wr, input vtrof_pkg::reg_idx_t idx,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= vtrof_pkg::APB_AW'({idx, 2'b00});
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_reg(input vtrof_pkg::reg_idx_t idx);
		logic [31:0] got;
		logic [31:0] want;
		apb_access(1'b0, idx, '0, got);
		want = (idx == vtrof_pkg::REG_ROW_LENGTH) ? 32'(len_reg) : 32'(rows_reg);
		if (got !== want)
			flag_error((idx == vtrof_pkg::REG_ROW_LENGTH) ? "row_length read-back"
				: "row_count read-back", want, got);
	endtask

	task automatic set_reg(input vtrof_pkg::reg_idx_t idx, input int value);
		logic [31:0] unused;
		apb_access(1'b1, idx, 32'(value), unused);
		if (idx == vtrof_pkg::REG_ROW_LENGTH)
			len_reg = vtrof_pkg::LEN_W'(value);
		else
			rows_reg = vtrof_pkg::ROWS_W'(value);
		reg_writes++;
		check_reg(idx);
		@(negedge clk);
	endtask

	task automatic queue_req(input vtrof_pkg::op_t op, input logic [7:0] b,
			input logic [7:0] g, input logic [7:0] r);
		pixel_req_t req;
		req.op    = op;
		req.blue  = b;
		req.green = g;
		req.red   = r;
		request_q.push_back(req);
	endtask

	// Sparse pixels keep the OR of three rows from saturating to all ones.
	function automatic logic [7:0] rand_channel();
		unique case ($urandom_range(3))
			0:       return 8'h00;
			1:       return 8'(1 << $urandom_range(7));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Pixels of a frame followed by its drain ticks, with stray drain ticks
	// among the pixels and stray pixels among the drain ticks.
	task automatic send_frame(input int npix, input int ndrain);
		for (int i = 0; i < npix; i++) begin
			if ($urandom_range(24) == 0)
				queue_req(vtrof_pkg::OP_DRAIN, rand_channel(), rand_channel(),
					rand_channel());
			queue_req(vtrof_pkg::OP_PIXEL, rand_channel(), rand_channel(), rand_channel());
		end
		for (int i = 0; i < ndrain; i++) begin
			if ($urandom_range(11) == 0)
				queue_req(vtrof_pkg::OP_PIXEL, rand_channel(), rand_channel(),
					rand_channel());
			queue_req(vtrof_pkg::OP_DRAIN, rand_channel(), rand_channel(), rand_channel());
		end
		shaped_count += npix + ndrain;
	endtask

	// Waits until every request is taken and every result has arrived, then
	// lets the pipeline empty of requests that give no result.
	task automatic settle();
		while (request_q.size() != 0 || s_tvalid || filtered_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		int len;
		int rows;
		int new_len;
		int new_rows;
		int k;
		int x;
		int r;
		int nframes;
		int extreme_len[6];
		int extreme_rows[6];
		extreme_len  = '{1024, 2047, 1, 0, 5, 1};
		extreme_rows = '{2, 1, 4095, 3, 0, 1};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_reg(vtrof_pkg::REG_ROW_LENGTH);
		check_reg(vtrof_pkg::REG_ROW_COUNT);

		// Directed: a 3x3 frame with extreme and walking-bit pixels.
		send_idle_pct = 20;
		stall_pct     = 20;
		set_reg(vtrof_pkg::REG_ROW_LENGTH, 3);
		set_reg(vtrof_pkg::REG_ROW_COUNT, 3);
		queue_req(vtrof_pkg::OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
		queue_req(vtrof_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
		queue_req(vtrof_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		queue_req(vtrof_pkg::OP_PIXEL, 8'h01, 8'h02, 8'h04);
		queue_req(vtrof_pkg::OP_PIXEL, 8'h80, 8'h00, 8'h00);
		queue_req(vtrof_pkg::OP_PIXEL, 8'h00, 8'h40, 8'h00);
		queue_req(vtrof_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h20);
		queue_req(vtrof_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
		queue_req(vtrof_pkg::OP_PIXEL, 8'h0F, 8'hF0, 8'h00);
		queue_req(vtrof_pkg::OP_PIXEL, 8'h10, 8'h08, 8'h04);
		// This pixel falls while the last row drains and must be dropped.
		queue_req(vtrof_pkg::OP_PIXEL, 8'hAA, 8'h55, 8'hAA);
		repeat (4) queue_req(vtrof_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
		settle();

		// Directed: a single-row frame passes through unchanged on the drain.
		set_reg(vtrof_pkg::REG_ROW_LENGTH, 2);
		set_reg(vtrof_pkg::REG_ROW_COUNT, 1);
		queue_req(vtrof_pkg::OP_PIXEL, 8'h12, 8'h34, 8'h56);
		queue_req(vtrof_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'h80);
		queue_req(vtrof_pkg::OP_DRAIN, 8'h5A, 8'hA5, 8'h5A);
		queue_req(vtrof_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
		settle();

		// Register extremes, including values that clamp. A large geometry runs
		// only the start of a frame and is then shrunk, so that the positions
		// clamp and the frame closes after a few more pixels.
		for (int i = 0; i < 6; i++) begin
			send_idle_pct = (i % 2 == 0) ? 0 : 15;
			stall_pct     = (i % 3 == 0) ? 0 : 15;
			set_reg(vtrof_pkg::REG_ROW_LENGTH, extreme_len[i]);
			set_reg(vtrof_pkg::REG_ROW_COUNT, extreme_rows[i]);
			len  = active_len();
			rows = active_rows();
			if (len * rows <= 64) begin
				send_frame(len * rows, len);
			end else begin
				k = $urandom_range(2, 40);
				send_frame(k, 0);
				settle();
				new_len  = (len < 4) ? len : 4;
				new_rows = 3;
				set_reg(vtrof_pkg::REG_ROW_LENGTH, new_len);
				set_reg(vtrof_pkg::REG_ROW_COUNT, new_rows);
				x = (k % len < new_len) ? k % len : new_len - 1;
				r = (k / len < new_rows) ? k / len : new_rows - 1;
				send_frame((new_rows - 1 - r) * new_len + (new_len - x), new_len);
			end
			settle();
		end

		shaped_count = 0;
		while (shaped_count < RANDOM_ITEMS) begin
			send_idle_pct = $urandom_range(2) * 20;
			stall_pct     = $urandom_range(2) * 20;
			len  = ($urandom_range(7) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
			rows = ($urandom_range(7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			set_reg(vtrof_pkg::REG_ROW_LENGTH, len);
			set_reg(vtrof_pkg::REG_ROW_COUNT, rows);
			nframes = $urandom_range(1, 3);
			for (int f = 0; f < nframes; f++) begin
				if ($urandom_range(3) == 0)
					queue_req(vtrof_pkg::OP_DRAIN, rand_channel(), rand_channel(),
						rand_channel());
				if (f == nframes - 1 && len * rows > 1 && $urandom_range(3) == 0) begin
					// Stop mid-frame and shrink the geometry; the positions clamp.
					// Row length only shrinks, so no unwritten buffer entry is read.
					k = $urandom_range(1, len * rows - 1);
					send_frame(k, 0);
					settle();
					new_len  = $urandom_range(1, len);
					new_rows = $urandom_range(1, 8);
					set_reg(vtrof_pkg::REG_ROW_LENGTH, new_len);
					set_reg(vtrof_pkg::REG_ROW_COUNT, new_rows);
					x = (k % len < new_len) ? k % len : new_len - 1;
					r = (k / len < new_rows) ? k / len : new_rows - 1;
					send_frame((new_rows - 1 - r) * new_len + (new_len - x), new_len);
				end else begin
					send_frame(len * rows, len);
				end
			end
			settle();
		end

		// Closing stretch with no idling on either side.
		send_idle_pct = 0;
		stall_pct     = 0;
		set_reg(vtrof_pkg::REG_ROW_LENGTH, 4);
		set_reg(vtrof_pkg::REG_ROW_COUNT, 3);
		send_frame(12, 4);
		settle();

		$display("Covered %0d requests and %0d checked results over %0d frames,",
			requests_taken, results_seen, frames_seen);
		$display("with %0d register writes and %0d errors.", reg_writes, error_count);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
